// File: src/fcm_pkg.sv
// Shared types and constants of the fundamental cycle marker.
`default_nettype none

package fcm_pkg;

    // Vertex fields are 12 bits wide; every index wraps inside the vertex range.
    localparam int V_W          = 12;
    localparam int MAX_VERTICES = 2 ** V_W;
    // Step counter must be able to hold MAX_VERTICES itself.
    localparam int STEP_W       = V_W + 1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [V_W-1:0] vertex_a;
        logic [V_W-1:0] vertex_b;
        logic [V_W-1:0] tree_depth;
    } t_in_item;

    typedef struct packed {
        logic [V_W-1:0] base_a;
        logic [V_W-1:0] base_b;
        logic [V_W-1:0] meeting_vertex;
        logic           back_edge;
        logic           flag_on_cycle;
        logic           flag_unfinished;
        logic           flag_meeting;
        logic           flag_base;
        logic           is_bridge;
    } t_out_item;

    typedef struct packed {
        logic [V_W-1:0] parent;
        logic [V_W-1:0] depth;
    } t_tree_ent;

    typedef struct packed {
        logic           we;
        logic [V_W-1:0] addr;
        t_tree_ent      ent;
    } t_tree_wr;

    typedef struct packed {
        logic on_cycle;
        logic unfinished;
        logic meeting;
        logic base;
    } t_flags;

    // One write port per flag array, each with its own address.
    typedef struct packed {
        logic           cyc_we;
        logic [V_W-1:0] cyc_addr;
        logic           int_we;
        logic [V_W-1:0] int_addr;
        logic           meet_we;
        logic [V_W-1:0] meet_addr;
        logic           base_we;
        logic [V_W-1:0] base_addr;
        logic           wdata;
    } t_flag_wr;

endpackage

`default_nettype wire

// File: src/fcm_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface fcm_in_if import fcm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fcm_out_if import fcm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/fundamental_cycle_marker_unit.sv
// Top level of the fundamental cycle marker: memories, sequencer, result register.
//
//   channel    | modport | payload
//   -----------+---------+---------------------------------------------------
//   i_item     | sink    | cmd, vertex_a, vertex_b, tree_depth
//   o_result   | source  | base_a, base_b, meeting_vertex, back_edge, flags
//
// An add climbs the tree, every climb step of each end being one read of
// the tree memory; a back edge closes sooner, skipping the final marking.
// After reset a clearing pass zeroes the flag arrays; no item is accepted
// meanwhile. Tree contents are not cleared.
// A result waits in the output register; a further result stalls the
// sequencer until the register is taken.
`default_nettype none

module fundamental_cycle_marker_unit import fcm_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    fcm_in_if.sink    i_item,
    fcm_out_if.source o_result
);

    t_tree_wr       tree_wr;
    logic [V_W-1:0] tree_raddr;
    t_tree_ent      tree_rd;
    t_flag_wr       flag_wr;
    logic [V_W-1:0] flag_raddr;
    t_flags         flag_rd;
    logic           res_valid;
    logic           res_take;
    t_out_item      res;
    logic           item_ready;

    logic      r_ovalid;
    t_out_item r_odata;

    fcm_tree_mem u_tree (
        .i_clk   (i_clk),
        .i_wr    (tree_wr),
        .i_raddr (tree_raddr),
        .o_rdata (tree_rd)
    );

    fcm_flag_mem u_flags (
        .i_clk   (i_clk),
        .i_wr    (flag_wr),
        .i_raddr (flag_raddr),
        .o_rdata (flag_rd)
    );

    fcm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_item       (i_item.data),
        .o_item_ready (item_ready),
        .i_tree_rd    (tree_rd),
        .o_tree_wr    (tree_wr),
        .o_tree_raddr (tree_raddr),
        .i_flags      (flag_rd),
        .o_flag_wr    (flag_wr),
        .o_flag_raddr (flag_raddr),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    assign i_item.ready = item_ready;

    // Load the output register when it is empty or being drained this cycle.
    assign res_take = !r_ovalid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_odata <= res;
        end
    end

    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_odata;

endmodule

`default_nettype wire

// File: src/fcm_tree_mem.sv
// Parent and depth memory of the spanning tree, one write and one read port.
`default_nettype none

module fcm_tree_mem import fcm_pkg::*; (
    input  wire logic           i_clk,
    input  wire t_tree_wr       i_wr,
    input  wire logic [V_W-1:0] i_raddr,
    output t_tree_ent           o_rdata
);

    t_tree_ent r_mem [MAX_VERTICES];
    t_tree_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.ent;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/fcm_flag_mem.sv
// Four per-vertex flag arrays, each with its own write port, read together.
`default_nettype none

module fcm_flag_mem import fcm_pkg::*; (
    input  wire logic           i_clk,
    input  wire t_flag_wr       i_wr,
    input  wire logic [V_W-1:0] i_raddr,
    output t_flags              o_rdata
);

    logic   r_cyc  [MAX_VERTICES];
    logic   r_int  [MAX_VERTICES];
    logic   r_meet [MAX_VERTICES];
    logic   r_base [MAX_VERTICES];
    t_flags r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.cyc_we) begin
            r_cyc[i_wr.cyc_addr] <= i_wr.wdata;
        end
        if (i_wr.int_we) begin
            r_int[i_wr.int_addr] <= i_wr.wdata;
        end
        if (i_wr.meet_we) begin
            r_meet[i_wr.meet_addr] <= i_wr.wdata;
        end
        if (i_wr.base_we) begin
            r_base[i_wr.base_addr] <= i_wr.wdata;
        end
        r_rdata.on_cycle   <= r_cyc[i_raddr];
        r_rdata.unfinished <= r_int[i_raddr];
        r_rdata.meeting    <= r_meet[i_raddr];
        r_rdata.base       <= r_base[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/fcm_seq.sv
// Sequencer: clear pass, tree loads, tree climbing of add items, flag reads.
`default_nettype none

module fcm_seq import fcm_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  wire t_in_item       i_item,
    output logic                o_item_ready,
    input  wire t_tree_ent      i_tree_rd,
    output t_tree_wr            o_tree_wr,
    output logic [V_W-1:0]      o_tree_raddr,
    input  wire t_flags         i_flags,
    output t_flag_wr            o_flag_wr,
    output logic [V_W-1:0]      o_flag_raddr,
    output logic                o_res_valid,
    input  wire logic           i_res_take,
    output t_out_item           o_res
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_LD_U   = 5'd2;
    localparam logic [4:0] S_LD_V   = 5'd3;
    localparam logic [4:0] S_LD_W   = 5'd4;
    localparam logic [4:0] S_P1     = 5'd5;
    localparam logic [4:0] S_P1_RD  = 5'd6;
    localparam logic [4:0] S_P1_CHK = 5'd7;
    localparam logic [4:0] S_P2     = 5'd8;
    localparam logic [4:0] S_P2_RD  = 5'd9;
    localparam logic [4:0] S_P2_CHK = 5'd10;
    localparam logic [4:0] S_P3     = 5'd11;
    localparam logic [4:0] S_P3_U   = 5'd12;
    localparam logic [4:0] S_P3_V   = 5'd13;
    localparam logic [4:0] S_P3_W   = 5'd14;
    localparam logic [4:0] S_FIN    = 5'd15;
    localparam logic [4:0] S_FIN2   = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;
    localparam logic [4:0] S_RD     = 5'd18;
    localparam logic [4:0] S_RD_DAT = 5'd19;

    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_VERTICES);
    localparam logic [V_W-1:0]    CLR_LAST   = V_W'(MAX_VERTICES - 1);

    logic [4:0]        r_state, n_state;
    logic [V_W-1:0]    r_clr, n_clr;
    logic [STEP_W-1:0] r_n, n_n;
    logic [V_W-1:0]    r_u, n_u, r_v, n_v;
    logic [V_W-1:0]    r_du, n_du, r_dv, n_dv;
    logic [V_W-1:0]    r_pu, n_pu, r_pv, n_pv;
    t_out_item         r_res, n_res;

    logic accept;
    logic steps_left;
    logic climb_v, climb_u;

    assign o_item_ready = (r_state == S_IDLE);
    assign accept       = i_item_valid && o_item_ready;
    assign steps_left   = (r_n < STEP_LIMIT);
    // Keep climbing while the parent just read still sits below the other end.
    assign climb_v      = steps_left && (r_du < i_tree_rd.depth);
    assign climb_u      = steps_left && (r_dv < i_tree_rd.depth);

    assign o_res_valid  = (r_state == S_OUT);
    assign o_res        = r_res;
    assign o_flag_raddr = r_u;

    always_comb begin
        o_tree_wr.we     = accept && (i_item.cmd == CMD_LOAD);
        o_tree_wr.addr   = i_item.vertex_a;
        o_tree_wr.ent    = '{parent: i_item.vertex_b, depth: i_item.tree_depth};
    end

    always_comb begin
        case (r_state)
            S_LD_V:  o_tree_raddr = r_v;
            S_P1_RD: o_tree_raddr = r_pv;
            S_P2_RD: o_tree_raddr = r_pu;
            S_P3_U:  o_tree_raddr = r_pu;
            S_P3_V:  o_tree_raddr = r_pv;
            default: o_tree_raddr = r_u;
        endcase
    end

    always_comb begin
        o_flag_wr       = '0;
        o_flag_wr.wdata = (r_state != S_CLR);
        case (r_state)
            S_CLR: begin
                o_flag_wr.cyc_we    = 1'b1;
                o_flag_wr.cyc_addr  = r_clr;
                o_flag_wr.int_we    = 1'b1;
                o_flag_wr.int_addr  = r_clr;
                o_flag_wr.meet_we   = 1'b1;
                o_flag_wr.meet_addr = r_clr;
                o_flag_wr.base_we   = 1'b1;
                o_flag_wr.base_addr = r_clr;
            end
            S_P1_CHK: begin
                if (!climb_v && (r_pv == r_u)) begin
                    o_flag_wr.meet_we   = 1'b1;
                    o_flag_wr.meet_addr = r_u;
                    o_flag_wr.cyc_we    = 1'b1;
                    o_flag_wr.cyc_addr  = r_v;
                    o_flag_wr.base_we   = 1'b1;
                    o_flag_wr.base_addr = r_v;
                end else begin
                    o_flag_wr.cyc_we    = 1'b1;
                    o_flag_wr.cyc_addr  = r_v;
                    o_flag_wr.int_we    = 1'b1;
                    o_flag_wr.int_addr  = r_v;
                end
            end
            S_P2_CHK: begin
                if (!climb_u && (r_pu == r_v)) begin
                    o_flag_wr.meet_we   = 1'b1;
                    o_flag_wr.meet_addr = r_v;
                    o_flag_wr.cyc_we    = 1'b1;
                    o_flag_wr.cyc_addr  = r_u;
                    o_flag_wr.base_we   = 1'b1;
                    o_flag_wr.base_addr = r_u;
                end else begin
                    o_flag_wr.cyc_we    = 1'b1;
                    o_flag_wr.cyc_addr  = r_u;
                    o_flag_wr.int_we    = 1'b1;
                    o_flag_wr.int_addr  = r_u;
                end
            end
            S_P3_U: begin
                o_flag_wr.cyc_we   = 1'b1;
                o_flag_wr.cyc_addr = r_u;
                o_flag_wr.int_we   = 1'b1;
                o_flag_wr.int_addr = r_u;
            end
            S_P3_V: begin
                o_flag_wr.cyc_we   = 1'b1;
                o_flag_wr.cyc_addr = r_v;
                o_flag_wr.int_we   = 1'b1;
                o_flag_wr.int_addr = r_v;
            end
            S_FIN: begin
                o_flag_wr.cyc_we    = 1'b1;
                o_flag_wr.cyc_addr  = r_u;
                o_flag_wr.base_we   = 1'b1;
                o_flag_wr.base_addr = r_u;
                o_flag_wr.meet_we   = 1'b1;
                o_flag_wr.meet_addr = r_pu;
            end
            S_FIN2: begin
                o_flag_wr.cyc_we    = 1'b1;
                o_flag_wr.cyc_addr  = r_v;
                o_flag_wr.base_we   = 1'b1;
                o_flag_wr.base_addr = r_v;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_n     = r_n;
        n_u     = r_u;
        n_v     = r_v;
        n_du    = r_du;
        n_dv    = r_dv;
        n_pu    = r_pu;
        n_pv    = r_pv;
        n_res   = r_res;
        case (r_state)
            S_CLR: begin
                n_clr = r_clr + V_W'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_u = i_item.vertex_a;
                    n_v = i_item.vertex_b;
                    case (i_item.cmd)
                        CMD_ADD:  n_state = S_LD_U;
                        CMD_READ: n_state = S_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_U: n_state = S_LD_V;
            S_LD_V: begin
                n_du    = i_tree_rd.depth;
                n_pu    = i_tree_rd.parent;
                n_state = S_LD_W;
            end
            S_LD_W: begin
                n_dv    = i_tree_rd.depth;
                n_pv    = i_tree_rd.parent;
                n_state = S_P1;
            end
            S_P1: begin
                n_n     = '0;
                n_state = (r_du < r_dv) ? S_P1_RD : S_P2;
            end
            S_P1_RD: n_state = S_P1_CHK;
            S_P1_CHK: begin
                if (!climb_v && (r_pv == r_u)) begin
                    n_res                = '0;
                    n_res.base_a         = r_u;
                    n_res.base_b         = r_v;
                    n_res.meeting_vertex = r_u;
                    n_res.back_edge      = 1'b1;
                    n_state              = S_OUT;
                end else begin
                    // Step v up to its parent; the entry read is the parent's.
                    n_v     = r_pv;
                    n_dv    = i_tree_rd.depth;
                    n_pv    = i_tree_rd.parent;
                    n_n     = climb_v ? (r_n + STEP_W'(1)) : '0;
                    n_state = climb_v ? S_P1_RD : S_P2;
                end
            end
            S_P2: begin
                n_n     = '0;
                n_state = (r_dv < r_du) ? S_P2_RD : S_P3;
            end
            S_P2_RD: n_state = S_P2_CHK;
            S_P2_CHK: begin
                if (!climb_u && (r_pu == r_v)) begin
                    n_res                = '0;
                    n_res.base_a         = r_u;
                    n_res.base_b         = r_v;
                    n_res.meeting_vertex = r_v;
                    n_res.back_edge      = 1'b1;
                    n_state              = S_OUT;
                end else begin
                    n_u     = r_pu;
                    n_du    = i_tree_rd.depth;
                    n_pu    = i_tree_rd.parent;
                    n_n     = climb_u ? (r_n + STEP_W'(1)) : '0;
                    n_state = climb_u ? S_P2_RD : S_P3;
                end
            end
            S_P3: begin
                n_state = (steps_left && (r_pu != r_pv)) ? S_P3_U : S_FIN;
            end
            S_P3_U: n_state = S_P3_V;
            S_P3_V: begin
                n_u     = r_pu;
                n_du    = i_tree_rd.depth;
                n_pu    = i_tree_rd.parent;
                n_state = S_P3_W;
            end
            S_P3_W: begin
                n_v     = r_pv;
                n_dv    = i_tree_rd.depth;
                n_pv    = i_tree_rd.parent;
                n_n     = r_n + STEP_W'(1);
                n_state = S_P3;
            end
            S_FIN: n_state = S_FIN2;
            S_FIN2: begin
                n_res                = '0;
                n_res.base_a         = r_u;
                n_res.base_b         = r_v;
                n_res.meeting_vertex = r_pu;
                n_state              = S_OUT;
            end
            S_OUT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: n_state = S_RD_DAT;
            S_RD_DAT: begin
                n_res                 = '0;
                n_res.flag_on_cycle   = i_flags.on_cycle;
                n_res.flag_unfinished = i_flags.unfinished;
                n_res.flag_meeting    = i_flags.meeting;
                n_res.flag_base       = i_flags.base;
                n_res.is_bridge       = (i_tree_rd.parent != r_u) && !i_flags.on_cycle;
                n_state               = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_du  <= n_du;
        r_dv  <= n_dv;
        r_pu  <= n_pu;
        r_pv  <= n_pv;
        r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_tree_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tree_wr.we |-> (r_state == S_IDLE))
        else $error("tree memory written outside idle");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_take) |=> (o_res_valid && $stable(r_res)))
        else $error("pending result changed before it was taken");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= STEP_LIMIT)
        else $error("climb step counter past its limit");

    a_add_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.cmd == CMD_ADD)) |=> (r_state == S_LD_U))
        else $error("add item did not start its climb");
`endif

endmodule

`default_nettype wire
